FILE: src/esc_pkg.sv
// Shared types and constants of the environmental sensor compensation core.
`default_nettype none

package esc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 48;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned DIV_STAGES  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMP     = 3'd0,
        REG_PRES_LO  = 3'd1,
        REG_PRES_MID = 3'd2,
        REG_PRES_HI  = 3'd3,
        REG_HUM_A    = 3'd4,
        REG_HUM_B    = 3'd5
    } cfg_idx_t;

    localparam logic signed [32:0] TEMP_P_OFFSET  = 33'sd128000;
    localparam logic [31:0]        TEMP_ROUND     = 32'd128;
    localparam logic signed [31:0] TEMP_MAX       = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN       = -32'sd32768;
    localparam logic [20:0]        PRES_BASE      = 21'd1048576;
    localparam logic [31:0]        PRES_SCALE     = 32'd3125;
    localparam logic [63:0]        PRES_VAR1_BIAS = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        HUM_T_OFFSET   = 32'd76800;
    localparam logic signed [31:0] HUM_X_ROUND    = 32'sd16384;
    localparam logic signed [31:0] HUM_W_BIAS     = 32'sd2097152;
    localparam logic signed [31:0] HUM_Z_BIAS     = 32'sd32768;
    localparam logic signed [31:0] HUM_W_ROUND    = 32'sd8192;
    localparam logic signed [31:0] HUM_LIMIT      = 32'sd419430400;
    localparam logic [16:0]        HUM_OUT_MAX    = 17'd102400;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [15:0] h4;
        logic [15:0] h5;
        logic [7:0]  h6;
    } coef_t;

    // Fine temperature and the raw pressure and humidity of one request.
    typedef struct packed {
        logic [31:0] tf;
        logic [19:0] ap;
        logic [15:0] ah;
    } tsample_t;

    typedef struct packed {
        logic        flag;
        logic [15:0] tc;
        logic [16:0] hum;
    } side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [63:0] num;
        logic [30:0] dvs;
        logic        neg;
        side_t       side;
    } div_stage_t;

endpackage

`default_nettype wire

FILE: src/esc_fifo.sv
// Short queue between the temperature front end and the back end.
`default_nettype none

module esc_fifo
    import esc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire tsample_t din,
    output logic          full,
    input  wire logic     pop,
    output tsample_t      dout,
    output logic          empty
);

    localparam logic [FIFO_PTR_W:0] FULL_CNT = FIFO_DEPTH[FIFO_PTR_W:0];

    tsample_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= FULL_CNT)
        else $error("queue count exceeds its depth");

endmodule

`default_nettype wire

FILE: src/esc_front.sv
// Front end: accepts raw samples and computes the fine temperature.
`default_nettype none

module esc_front
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire coef_t       coef,
    input  wire logic        push,
    output logic             full,
    input  wire logic [19:0] raw_temperature,
    input  wire logic [19:0] raw_pressure,
    input  wire logic [15:0] raw_humidity,
    output logic             q_push,
    output tsample_t         q_data,
    input  wire logic        q_full
);

    logic [3:0]         vld_reg;
    logic               en;
    logic signed [31:0] t2_x;
    logic signed [31:0] t3_x;

    logic signed [31:0] s1_reg;
    logic [31:0]        d_reg;
    logic signed [31:0] v1a_reg;
    logic signed [31:0] dd_reg;
    logic signed [31:0] v1_reg;
    logic signed [31:0] m_reg;
    logic signed [31:0] tf_reg;
    logic [19:0]        ap_reg [4];
    logic [15:0]        ah_reg [4];

    logic signed [31:0] v1_next;
    logic signed [31:0] dds_next;
    logic signed [31:0] ms_next;

    assign t2_x    = $signed({{16{coef.t2[15]}}, coef.t2});
    assign t3_x    = $signed({{16{coef.t3[15]}}, coef.t3});
    assign en      = !vld_reg[3] || !q_full;
    assign full    = !en;
    assign q_push  = vld_reg[3] && !q_full;
    assign q_data  = '{tf: tf_reg, ap: ap_reg[3], ah: ah_reg[3]};

    assign v1_next  = v1a_reg >>> 11;
    assign dds_next = dd_reg >>> 12;
    assign ms_next  = m_reg >>> 14;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= $signed({15'd0, raw_temperature[19:3]} - {15'd0, coef.t1, 1'b0});
            d_reg   <= {16'd0, raw_temperature[19:4]} - {16'd0, coef.t1};
            v1a_reg <= s1_reg * t2_x;
            dd_reg  <= $signed(d_reg * d_reg);
            v1_reg  <= v1_next;
            m_reg   <= dds_next * t3_x;
            tf_reg  <= v1_reg + ms_next;
            ap_reg[0] <= raw_pressure;
            ah_reg[0] <= raw_humidity;
            for (int i = 1; i < 4; i++)
            begin
                ap_reg[i] <= ap_reg[i-1];
                ah_reg[i] <= ah_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], push};
        end
    end

endmodule

`default_nettype wire

FILE: src/esc_div.sv
// Pipelined unsigned divider, one quotient bit per stage, with side data.
`default_nettype none

module esc_div
    import esc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       din_valid,
    input  wire div_stage_t din,
    output logic            dout_valid,
    output div_stage_t      dout
);

    div_stage_t            stg_reg [DIV_STAGES];
    div_stage_t            stg_in  [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;

    // One restoring step: shift in the next dividend bit and try a subtract.
    function automatic div_stage_t div_step(div_stage_t s);
        div_stage_t  r;
        logic [31:0] sh;
        logic [32:0] tr;
        r  = s;
        sh = {s.rem[30:0], s.num[63]};
        tr = {1'b0, sh} - {2'b00, s.dvs};
        if (!tr[32])
        begin
            r.rem = tr[31:0];
            r.num = {s.num[62:0], 1'b1};
        end
        else
        begin
            r.rem = sh;
            r.num = {s.num[62:0], 1'b0};
        end
        return r;
    endfunction

    assign stg_in[0] = din;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        if (g > 0)
        begin : g_link
            assign stg_in[g] = stg_reg[g-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[g] <= div_step(stg_in[g]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], din_valid};
        end
    end

    assign dout_valid = vld_reg[DIV_STAGES-1];
    assign dout       = stg_reg[DIV_STAGES-1];

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STAGES-1] |->
            stg_reg[DIV_STAGES-1].rem < {1'b0, stg_reg[DIV_STAGES-1].dvs})
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: src/esc_back.sv
// Back end: pressure and humidity polynomials, divider and result register.
`default_nettype none

module esc_back
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire coef_t       coef,
    input  wire logic        q_empty,
    input  wire tsample_t    q_data,
    output logic             q_pop,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      temperature_centi,
    output logic [31:0]      pressure_q24_8,
    output logic             pressure_divisor_zero,
    output logic [16:0]      humidity_q22_10
);

    logic        adv;
    logic [11:0] pv_reg;
    logic [6:0]  qv_reg;

    logic [31:0] p6_x, p3_x, p8_x, p9_x, p7_x;
    logic signed [31:0] h1_s, h2_s, h3_s, h4_s, h5_s, h6_s;

    // Pre-division stages
    logic signed [32:0] a1_reg;
    logic signed [31:0] hv1_reg;
    logic [15:0]        tc_reg [12];
    logic [20:0]        p0_reg [5];
    logic [15:0]        ah_reg [2];
    logic [63:0]        aa2_reg;
    logic signed [48:0] ap5_reg [3];
    logic signed [48:0] ap2_reg [3];
    logic signed [31:0] hm5_reg, hy0_reg, hz0_reg;
    logic signed [48:0] pl6_reg, pl3_reg;
    logic [31:0]        ph6_reg, ph3_reg;
    logic signed [31:0] hx_reg [5];
    logic signed [31:0] hy3_reg, hz3_reg;
    logic [63:0]        b6_reg, a3_reg;
    logic signed [31:0] hyz_reg;
    logic [63:0]        b5_reg, ab5_reg;
    logic signed [31:0] hw5_reg;
    logic [63:0]        x6_reg, nd6_reg;
    logic signed [31:0] hwh_reg;
    logic [47:0]        pxl_reg;
    logic [31:0]        pxh_reg;
    logic [43:0]        ndl_reg;
    logic [31:0]        ndh_reg;
    logic signed [31:0] hw3_reg;
    logic [30:0]        a2_reg;
    logic [63:0]        num_reg;
    logic signed [31:0] hv2_reg [4];
    logic               flag_reg [4];
    logic [30:0]        dvs_reg [4];
    logic               neg_reg [4];
    logic [63:0]        nabs_reg [4];
    logic signed [31:0] hyy_reg, hyy2_reg, ht_reg;
    logic [16:0]        hum_reg;

    // Post-division stages
    logic [63:0]        p_reg [5];
    side_t              side_reg [6];
    logic [63:0]        ll_reg;
    logic [31:0]        lh_reg;
    logic signed [48:0] pl8_reg;
    logic [31:0]        ph8_reg;
    logic [63:0]        qq2_reg;
    logic [63:0]        c2_reg [3];
    logic signed [48:0] s9l_reg;
    logic [31:0]        s9h_reg;
    logic [63:0]        c1_reg;
    logic [63:0]        s6_reg;
    logic [15:0]        out_tc_reg;
    logic [31:0]        out_pres_reg;
    logic               out_flag_reg;
    logic [16:0]        out_hum_reg;

    // Combinational next values
    logic [31:0]        t5_next;
    logic signed [31:0] tcw_next;
    logic [15:0]        tc_next;
    logic signed [65:0] sq_next;
    logic signed [48:0] m5_next, m2_next;
    logic signed [31:0] hxs_next, hx_next;
    logic signed [63:0] a3s_next;
    logic [63:0]        px_next;
    logic [30:0]        dvs_next;
    logic signed [31:0] hv3_next;
    logic [16:0]        hum_next;
    logic               div_in_valid;
    div_stage_t         div_in;
    logic               div_out_valid;
    div_stage_t         div_out;
    logic signed [63:0] qq_next;
    logic [63:0]        c2s_next, c1s_next;
    logic signed [63:0] c2_next, c1_next;

    assign adv   = !qv_reg[6] || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !qv_reg[6];

    assign p3_x = {{16{coef.p3[15]}}, coef.p3};
    assign p6_x = {{16{coef.p6[15]}}, coef.p6};
    assign p7_x = {{16{coef.p7[15]}}, coef.p7};
    assign p8_x = {{16{coef.p8[15]}}, coef.p8};
    assign p9_x = {{16{coef.p9[15]}}, coef.p9};
    assign h1_s = $signed({24'd0, coef.h1});
    assign h2_s = $signed({{16{coef.h2[15]}}, coef.h2});
    assign h3_s = $signed({24'd0, coef.h3});
    assign h4_s = $signed({{16{coef.h4[15]}}, coef.h4});
    assign h5_s = $signed({{16{coef.h5[15]}}, coef.h5});
    assign h6_s = $signed({{24{coef.h6[7]}}, coef.h6});

    // Temperature output: (t_fine * 5 + 128) >> 8, saturated to 16 bits.
    assign t5_next  = q_data.tf + {q_data.tf[29:0], 2'b00} + TEMP_ROUND;
    assign tcw_next = $signed(t5_next) >>> 8;

    always_comb
    begin
        if (tcw_next > TEMP_MAX)
        begin
            tc_next = TEMP_MAX[15:0];
        end
        else if (tcw_next < TEMP_MIN)
        begin
            tc_next = TEMP_MIN[15:0];
        end
        else
        begin
            tc_next = tcw_next[15:0];
        end
    end

    assign sq_next  = a1_reg * a1_reg;
    assign m5_next  = a1_reg * $signed(coef.p5);
    assign m2_next  = a1_reg * $signed(coef.p2);
    assign hxs_next = $signed({2'b00, ah_reg[1], 14'd0}) - (h4_s <<< 20) - hm5_reg
                      + HUM_X_ROUND;
    assign hx_next  = hxs_next >>> 15;
    assign a3s_next = $signed(a3_reg) >>> 8;
    assign px_next  = {16'd0, pxl_reg} + {pxh_reg, 32'd0};
    assign dvs_next = a2_reg[30] ? (~a2_reg + 31'd1) : a2_reg;
    assign hv3_next = hv2_reg[3] - (ht_reg >>> 4);

    always_comb
    begin
        if (hv3_next < 0)
        begin
            hum_next = '0;
        end
        else if (hv3_next > HUM_LIMIT)
        begin
            hum_next = HUM_OUT_MAX;
        end
        else
        begin
            hum_next = hv3_next[28:12];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // B1
            a1_reg    <= $signed({q_data.tf[31], q_data.tf}) - TEMP_P_OFFSET;
            hv1_reg   <= $signed(q_data.tf - HUM_T_OFFSET);
            tc_reg[0] <= tc_next;
            p0_reg[0] <= PRES_BASE - {1'b0, q_data.ap};
            ah_reg[0] <= q_data.ah;
            for (int i = 1; i < 12; i++)
            begin
                tc_reg[i] <= tc_reg[i-1];
            end
            for (int i = 1; i < 5; i++)
            begin
                p0_reg[i] <= p0_reg[i-1];
            end
            ah_reg[1] <= ah_reg[0];
            // B2
            aa2_reg    <= sq_next[63:0];
            ap5_reg[0] <= m5_next;
            ap2_reg[0] <= m2_next;
            for (int i = 1; i < 3; i++)
            begin
                ap5_reg[i] <= ap5_reg[i-1];
                ap2_reg[i] <= ap2_reg[i-1];
            end
            hm5_reg <= hv1_reg * h5_s;
            hy0_reg <= hv1_reg * h6_s;
            hz0_reg <= hv1_reg * h3_s;
            // B3
            pl6_reg   <= $signed({1'b0, aa2_reg[31:0]}) * $signed(coef.p6);
            ph6_reg   <= aa2_reg[63:32] * p6_x;
            pl3_reg   <= $signed({1'b0, aa2_reg[31:0]}) * $signed(coef.p3);
            ph3_reg   <= aa2_reg[63:32] * p3_x;
            hx_reg[0] <= hx_next;
            for (int i = 1; i < 5; i++)
            begin
                hx_reg[i] <= hx_reg[i-1];
            end
            hy3_reg <= hy0_reg >>> 10;
            hz3_reg <= (hz0_reg >>> 11) + HUM_Z_BIAS;
            // B4
            b6_reg  <= {{15{pl6_reg[48]}}, pl6_reg} + {ph6_reg, 32'd0};
            a3_reg  <= {{15{pl3_reg[48]}}, pl3_reg} + {ph3_reg, 32'd0};
            hyz_reg <= hy3_reg * hz3_reg;
            // B5
            b5_reg  <= b6_reg + ({{15{ap5_reg[2][48]}}, ap5_reg[2]} << 17)
                       + ({{48{coef.p4[15]}}, coef.p4} << 35);
            ab5_reg <= a3s_next + ({{15{ap2_reg[2][48]}}, ap2_reg[2]} << 12);
            hw5_reg <= (hyz_reg >>> 10) + HUM_W_BIAS;
            // B6
            x6_reg  <= PRES_VAR1_BIAS + ab5_reg;
            nd6_reg <= {12'd0, p0_reg[4], 31'd0} - b5_reg;
            hwh_reg <= hw5_reg * h2_s;
            // B7
            pxl_reg <= x6_reg[31:0] * coef.p1;
            pxh_reg <= x6_reg[63:32] * {16'd0, coef.p1};
            ndl_reg <= nd6_reg[31:0] * PRES_SCALE[11:0];
            ndh_reg <= nd6_reg[63:32] * PRES_SCALE;
            hw3_reg <= (hwh_reg + HUM_W_ROUND) >>> 14;
            // B8: divisor is bits 63:33 of the wrapped product.
            a2_reg     <= px_next[63:33];
            num_reg    <= {20'd0, ndl_reg} + {ndh_reg, 32'd0};
            hv2_reg[0] <= hx_reg[4] * hw3_reg;
            for (int i = 1; i < 4; i++)
            begin
                hv2_reg[i] <= hv2_reg[i-1];
            end
            // B9: magnitudes and quotient sign; a zero divisor is replaced by one.
            flag_reg[0] <= (a2_reg == '0);
            dvs_reg[0]  <= (a2_reg == '0) ? 31'd1 : dvs_next;
            neg_reg[0]  <= num_reg[63] ^ a2_reg[30];
            nabs_reg[0] <= num_reg[63] ? (~num_reg + 64'd1) : num_reg;
            for (int i = 1; i < 4; i++)
            begin
                flag_reg[i] <= flag_reg[i-1];
                dvs_reg[i]  <= dvs_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                nabs_reg[i] <= nabs_reg[i-1];
            end
            hyy_reg  <= hv2_reg[0] >>> 15;
            // B10 .. B12
            hyy2_reg <= hyy_reg * hyy_reg;
            ht_reg   <= (hyy2_reg >>> 7) * h1_s;
            hum_reg  <= hum_next;
            // P1
            p_reg[0]    <= div_out.neg ? (~div_out.num + 64'd1) : div_out.num;
            side_reg[0] <= div_out.side;
            for (int i = 1; i < 5; i++)
            begin
                p_reg[i] <= p_reg[i-1];
            end
            for (int i = 1; i < 6; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            // P2: low 64 bits of q*q from a square and one cross term.
            ll_reg  <= qq_next[31:0] * qq_next[31:0];
            lh_reg  <= qq_next[31:0] * qq_next[63:32];
            pl8_reg <= $signed({1'b0, p_reg[0][31:0]}) * $signed(coef.p8);
            ph8_reg <= p_reg[0][63:32] * p8_x;
            // P3
            qq2_reg   <= ll_reg + {lh_reg[30:0], 33'd0};
            c2_reg[0] <= c2_next;
            for (int i = 1; i < 3; i++)
            begin
                c2_reg[i] <= c2_reg[i-1];
            end
            // P4
            s9l_reg <= $signed({1'b0, qq2_reg[31:0]}) * $signed(coef.p9);
            s9h_reg <= qq2_reg[63:32] * p9_x;
            // P5
            c1_reg <= c1_next;
            // P6
            s6_reg <= p_reg[4] + c1_reg + c2_reg[2];
            // P7
            out_tc_reg   <= side_reg[5].tc;
            out_flag_reg <= side_reg[5].flag;
            out_hum_reg  <= side_reg[5].hum;
            out_pres_reg <= side_reg[5].flag ? '0 : (s6_reg[39:8] + {p7_x[27:0], 4'd0});
        end
    end

    assign qq_next  = $signed(p_reg[0]) >>> 13;
    assign c2s_next = {{15{pl8_reg[48]}}, pl8_reg} + {ph8_reg, 32'd0};
    assign c2_next  = $signed(c2s_next) >>> 19;
    assign c1s_next = {{15{s9l_reg[48]}}, s9l_reg} + {s9h_reg, 32'd0};
    assign c1_next  = $signed(c1s_next) >>> 25;

    assign div_in_valid = pv_reg[11];
    assign div_in = '{rem: '0, num: nabs_reg[3], dvs: dvs_reg[3], neg: neg_reg[3],
                      side: '{flag: flag_reg[3], tc: tc_reg[11], hum: hum_reg}};

    esc_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .din_valid  (div_in_valid),
        .din        (div_in),
        .dout_valid (div_out_valid),
        .dout       (div_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            qv_reg <= '0;
        end
        else if (adv)
        begin
            pv_reg <= {pv_reg[10:0], q_pop};
            qv_reg <= {qv_reg[5:0], div_out_valid};
        end
    end

    assign temperature_centi     = out_tc_reg;
    assign pressure_q24_8        = out_pres_reg;
    assign pressure_divisor_zero = out_flag_reg;
    assign humidity_q22_10       = out_hum_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (qv_reg[6] && out_flag_reg) |-> (out_pres_reg == '0))
        else $error("pressure not forced to zero on a zero divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        qv_reg[6] |-> (out_hum_reg <= HUM_OUT_MAX))
        else $error("humidity above its clamp");

endmodule

`default_nettype wire

FILE: src/environmental_sensor_compensation_core.sv
// Top level: calibration registers, front end, queue and back end.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  samples   | push/full            | raw_temperature, raw_pressure, raw_humidity
//  results   | empty/pop            | temperature_centi, pressure_q24_8,
//            |                      | pressure_divisor_zero, humidity_q22_10
//
// One sample request is taken per cycle while full is low; most of the path from an
// accepted sample to its result lies in the 64-stage one-bit-per-stage divider.
// Reset clears the calibration registers, the queue and all valid bits.
// A result that is not popped stalls the back end; the four-entry queue and the
// front end keep taking samples until both are full.
`default_nettype none

module environmental_sensor_compensation_core
    import esc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [19:0]            raw_temperature,
    input  wire logic [19:0]            raw_pressure,
    input  wire logic [15:0]            raw_humidity,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [15:0]                 temperature_centi,
    output logic [31:0]                 pressure_q24_8,
    output logic                        pressure_divisor_zero,
    output logic [16:0]                 humidity_q22_10
);

    logic [47:0] temp_reg;
    logic [47:0] pres_lo_reg;
    logic [47:0] pres_mid_reg;
    logic [47:0] pres_hi_reg;
    logic [31:0] hum_a_reg;
    logic [39:0] hum_b_reg;
    coef_t       coef;

    logic        q_push;
    tsample_t    q_wdata;
    logic        q_full;
    logic        q_pop;
    tsample_t    q_rdata;
    logic        q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg     <= '0;
            pres_lo_reg  <= '0;
            pres_mid_reg <= '0;
            pres_hi_reg  <= '0;
            hum_a_reg    <= '0;
            hum_b_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_TEMP:     temp_reg     <= cfg_data;
                REG_PRES_LO:  pres_lo_reg  <= cfg_data;
                REG_PRES_MID: pres_mid_reg <= cfg_data;
                REG_PRES_HI:  pres_hi_reg  <= cfg_data;
                REG_HUM_A:    hum_a_reg    <= cfg_data[31:0];
                REG_HUM_B:    hum_b_reg    <= cfg_data[39:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        coef.t1 = temp_reg[15:0];
        coef.t2 = temp_reg[31:16];
        coef.t3 = temp_reg[47:32];
        coef.p1 = pres_lo_reg[15:0];
        coef.p2 = pres_lo_reg[31:16];
        coef.p3 = pres_lo_reg[47:32];
        coef.p4 = pres_mid_reg[15:0];
        coef.p5 = pres_mid_reg[31:16];
        coef.p6 = pres_mid_reg[47:32];
        coef.p7 = pres_hi_reg[15:0];
        coef.p8 = pres_hi_reg[31:16];
        coef.p9 = pres_hi_reg[47:32];
        coef.h1 = hum_a_reg[7:0];
        coef.h2 = hum_a_reg[23:8];
        coef.h3 = hum_a_reg[31:24];
        coef.h4 = hum_b_reg[15:0];
        coef.h5 = hum_b_reg[31:16];
        coef.h6 = hum_b_reg[39:32];
    end

    esc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .coef            (coef),
        .push            (push),
        .full            (full),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .raw_humidity    (raw_humidity),
        .q_push          (q_push),
        .q_data          (q_wdata),
        .q_full          (q_full)
    );

    esc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_rdata),
        .empty (q_empty)
    );

    esc_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .coef                  (coef),
        .q_empty               (q_empty),
        .q_data                (q_rdata),
        .q_pop                 (q_pop),
        .empty                 (empty),
        .pop                   (pop),
        .temperature_centi     (temperature_centi),
        .pressure_q24_8        (pressure_q24_8),
        .pressure_divisor_zero (pressure_divisor_zero),
        .humidity_q22_10       (humidity_q22_10)
    );

endmodule

`default_nettype wire

FILE: tb/environmental_sensor_compensation_core_test.sv
// Testbench of the environmental sensor compensation core: a predictor with a result queue.
`default_nettype none

module environmental_sensor_compensation_core_test;
    import esc_pkg::*;

    typedef struct {
        logic [15:0] tc;
        logic [31:0] pres;
        logic        flag;
        logic [16:0] hum;
    } reading_t;

    class reading_board;
        logic [47:0] regs [0:5];
        reading_t    pending[$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < 6; i++) regs[i] = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(int idx, logic [47:0] val);
            if (idx == REG_HUM_A) regs[idx] = {16'd0, val[31:0]};
            else if (idx == REG_HUM_B) regs[idx] = {8'd0, val[39:0]};
            else if (idx <= REG_HUM_B) regs[idx] = val;
        endfunction

        function logic signed [63:0] quot(logic signed [63:0] n, logic signed [63:0] dv);
            logic [63:0] un;
            logic [63:0] ud;
            logic [63:0] q;
            un = n[63] ? -n : n;
            ud = dv[63] ? -dv : dv;
            q = un / ud;
            return (n[63] != dv[63]) ? -q : q;
        endfunction

        function void note_sample(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
            reading_t r;
            logic signed [31:0] t1, t2, t3, d, v1, v2, tf, tc;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] a, b, p, q, c1, c2;
            logic signed [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w;
            t1 = {16'd0, regs[0][15:0]};
            t2 = {{16{regs[0][31]}}, regs[0][31:16]};
            t3 = {{16{regs[0][47]}}, regs[0][47:32]};
            v1 = ($signed({12'd0, at[19:3]}) - (t1 <<< 1)) * t2 >>> 11;
            d = $signed({12'd0, at[19:4]}) - t1;
            v2 = ((d * d) >>> 12) * t3 >>> 14;
            tf = v1 + v2;
            tc = (tf * 5 + 128) >>> 8;
            if (tc < -32768) r.tc = 16'h8000;
            else if (tc > 32767) r.tc = 16'h7fff;
            else r.tc = tc[15:0];

            p1 = {48'd0, regs[1][15:0]};
            p2 = $signed(regs[1][31:16]);
            p3 = $signed(regs[1][47:32]);
            p4 = $signed(regs[2][15:0]);
            p5 = $signed(regs[2][31:16]);
            p6 = $signed(regs[2][47:32]);
            p7 = $signed(regs[3][15:0]);
            p8 = $signed(regs[3][31:16]);
            p9 = $signed(regs[3][47:32]);
            a = 64'(tf) - 128000;
            b = a * a * p6;
            b = b + ((a * p5) <<< 17);
            b = b + (p4 <<< 35);
            a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
            a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
            r.flag = (a == 0);
            r.pres = '0;
            if (a != 0) begin
                p = 64'sd1048576 - $signed({44'd0, ap});
                p = quot(((p <<< 31) - b) * 3125, a);
                q = p >>> 13;
                c1 = (p9 * q * q) >>> 25;
                c2 = (p8 * p) >>> 19;
                p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
                r.pres = p[31:0];
            end

            h1 = {24'd0, regs[4][7:0]};
            h2 = $signed(regs[4][23:8]);
            h3 = {24'd0, regs[4][31:24]};
            h4 = $signed(regs[5][15:0]);
            h5 = $signed(regs[5][31:16]);
            h6 = $signed(regs[5][39:32]);
            v = tf - 76800;
            x = (($signed({16'd0, ah}) <<< 14) - (h4 <<< 20) - (h5 * v) + 16384) >>> 15;
            y = (v * h6) >>> 10;
            z = ((v * h3) >>> 11) + 32768;
            w = ((y * z) >>> 10) + 2097152;
            w = (w * h2 + 8192) >>> 14;
            v = x * w;
            y = v >>> 15;
            v = v - ((((y * y) >>> 7) * h1) >>> 4);
            if (v < 0) v = 0;
            else if (v > 419430400) v = 419430400;
            r.hum = v[28:12];
            pending.push_back(r);
        endfunction

        function void check_reading(logic [15:0] tc, logic [31:0] pres, logic flag,
                                    logic [16:0] hum);
            reading_t e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with none expected", $time);
                return;
            end
            e = pending.pop_front();
            if (tc !== e.tc) begin
                errors++;
                $display("%0t: temperature expected %h actual %h", $time, e.tc, tc);
            end
            if (pres !== e.pres) begin
                errors++;
                $display("%0t: pressure expected %h actual %h", $time, e.pres, pres);
            end
            if (flag !== e.flag) begin
                errors++;
                $display("%0t: divisor flag expected %b actual %b", $time, e.flag, flag);
            end
            if (hum !== e.hum) begin
                errors++;
                $display("%0t: humidity expected %h actual %h", $time, e.hum, hum);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic push;
    logic full;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
    logic empty;
    logic pop;
    logic [15:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic pressure_divisor_zero;
    logic [16:0] humidity_q22_10;

    environmental_sensor_compensation_core dut (.*);

    reading_board board;
    bit calm;
    bit drain_hold;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    task automatic write_reg(int idx, logic [47:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx[CFG_INDEX_W-1:0];
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        cfg_valid <= 0;
    endtask

    // Sends one request; push stays high while full stalls it.
    task automatic send_sample(logic [19:0] at, logic [19:0] ap, logic [15:0] ah);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            push <= 0;
            repeat (gap) @(posedge clk);
        end
        push <= 1;
        raw_temperature <= at;
        raw_pressure <= ap;
        raw_humidity <= ah;
        do @(posedge clk); while (full);
        board.note_sample(at, ap, ah);
    endtask

    task automatic drain();
        push <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Coefficients resembling a real part, with some randomness.
    task automatic plausible_regs();
        write_reg(REG_TEMP, {16'd50, 16'd26435, 16'd27504 + 16'($urandom_range(0, 200))});
        write_reg(REG_PRES_LO, {-16'sd3024, -16'sd10685, 16'd36477 + 16'($urandom_range(0, 99))});
        write_reg(REG_PRES_MID, {-16'sd7, 16'd140, 16'd2855});
        write_reg(REG_PRES_HI, {16'd6000, -16'sd14600, 16'd15500});
        write_reg(REG_HUM_A, {16'd0, 8'd0, 16'd359, 8'd75});
        write_reg(REG_HUM_B, {8'd0, 8'd30, 16'd50, 16'd339});
    endtask

    initial
    begin
        int phase;
        board = new();
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        push = 0;
        raw_temperature = '0;
        raw_pressure = '0;
        raw_humidity = '0;
        calm = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // All-zero coefficients: divisor is zero.
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hfffff, 20'hfffff, 16'hffff);
        drain();
        plausible_regs();
        send_sample(20'd519888, 20'd415148, 16'd27000);
        send_sample(20'd0, 20'd0, 16'd0);
        send_sample(20'hfffff, 20'hfffff, 16'hffff);
        send_sample(20'h80000, 20'h00001, 16'h8000);
        send_sample(20'd300000, 20'd1048575, 16'd65535);
        send_sample(20'd700000, 20'd0, 16'd0);
        drain();
        // Extreme coefficients: saturation, clamping and wrapping.
        write_reg(REG_TEMP, 48'h7fff_7fff_0000);
        write_reg(REG_PRES_LO, 48'hffff_ffff_ffff);
        write_reg(REG_HUM_A, 48'h0000_ffff_ffff);
        write_reg(REG_HUM_B, 48'h00ff_8000_8000);
        send_sample(20'hfffff, 20'h0, 16'hffff);
        send_sample(20'h0, 20'hfffff, 16'h0);
        drain();
        write_reg(7, rand48());
        write_reg(6, rand48());
        send_sample(20'h0, 20'h0, 16'h0);
        drain();
        write_reg(REG_TEMP, 48'h8000_8000_ffff);
        write_reg(REG_PRES_MID, 48'h8000_7fff_8000);
        write_reg(REG_PRES_HI, 48'h7fff_8000_7fff);
        send_sample(20'hfffff, 20'hfffff, 16'hffff);
        send_sample(20'h12345, 20'h54321, 16'h1234);
        drain();

        for (phase = 0; phase < 9; phase++)
        begin
            if (phase % 3 == 0) plausible_regs();
            else for (int i = 0; i < 6; i++) write_reg(i, rand48());
            if (phase == 8) calm = 1;
            if (phase == 2) drain_hold = 1;
            for (int n = 0; n < 200; n++)
            begin
                if (phase % 3 == 0)
                    send_sample(20'($urandom_range(400000, 600000)),
                                20'($urandom_range(250000, 500000)),
                                16'($urandom_range(20000, 40000)));
                else
                    send_sample(20'($urandom()), 20'($urandom()), 16'($urandom()));
            end
            drain();
        end

        $display("Checked %0d results over directed extremes and nine coefficient phases.",
                 board.checked);
        if (board.errors == 0)
            $display("environmental_sensor_compensation_core: match");
        else
            $display("environmental_sensor_compensation_core: mismatch");
        $finish;
    end

    // Receiver: random pops, with one long hold-off so the queue fills.
    initial
    begin
        int gap;
        pop = 0;
        drain_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.check_reading(temperature_centi, pressure_q24_8,
                                    pressure_divisor_zero, humidity_q22_10);
            if (drain_hold)
            begin
                drain_hold = 0;
                pop <= 0;
                repeat (400) @(posedge clk);
            end
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 19);
                pop <= 0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1;
        end
    end

    initial
    begin
        #4000000;
        $display("environmental_sensor_compensation_core: mismatch");
        $finish;
    end
endmodule

`default_nettype wire
